### hdl/refcounted_handle_table_top_macros.svh
// Assertion macros for the handle table.
// Included by the top level; no other dependencies.
`ifndef REFCOUNTED_HANDLE_TABLE_TOP_MACROS_SVH
`define REFCOUNTED_HANDLE_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RHT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("handle table assertion failed");
`define RHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("handle table assertion failed");
`else
`define RHT_ASSERT_SAME(label, clk, rst, ante, cons)
`define RHT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/rht_pkg.sv
// Shared types and constants for the handle table.
// No dependencies.
package rht_pkg;
   localparam int SLOTS_DEF      = 32;
   localparam int COUNT_BITS_DEF = 8;
   localparam int CMD_W          = 3;
   localparam int HANDLE_W       = 8;
   localparam int PAYLOAD_W      = 32;
   localparam int STATUS_W       = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_OPEN        = 3'd0,
      CMD_CLOSE       = 3'd1,
      CMD_LOOKUP      = 3'd2,
      CMD_ADDREF      = 3'd3,
      CMD_RELEASE_ALL = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_INVALID = 2'd2
   } status_type;

   typedef enum logic {
      CNT_INC = 1'b0,
      CNT_DEC = 1'b1
   } cnt_op_type;
endpackage

### hdl/rht_req_if.sv
// Command channel of the handle table.
// Depends on rht_pkg.
interface rht_req_if;
   logic                          valid;
   logic                          ready;
   logic [rht_pkg::CMD_W-1:0]     command;
   logic [rht_pkg::HANDLE_W-1:0]  handle;
   logic [rht_pkg::PAYLOAD_W-1:0] payload;

   modport source (output valid, command, handle, payload, input ready);
   modport sink   (input valid, command, handle, payload, output ready);
endinterface

### hdl/rht_rsp_if.sv
// Result channel of the handle table.
// Depends on rht_pkg.
interface rht_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rht_pkg::STATUS_W-1:0]  status;
   logic [rht_pkg::HANDLE_W-1:0]  slot;
   logic [rht_pkg::PAYLOAD_W-1:0] payload_out;
   logic                          is_open;

   modport source (output valid, status, slot, payload_out, is_open, input ready);
   modport sink   (input valid, status, slot, payload_out, is_open, output ready);
endinterface

### hdl/rht_count_unit.sv
// Shared reference count adder: saturating increment, floored decrement.
// Depends on rht_pkg.
module rht_count_unit #(
   parameter int COUNT_BITS = rht_pkg::COUNT_BITS_DEF
) (
   input  logic [COUNT_BITS-1:0] cnt_i,
   input  rht_pkg::cnt_op_type   op_i,
   output logic [COUNT_BITS-1:0] cnt_o,
   output logic                  zero_o
);
   import rht_pkg::*;

   logic [COUNT_BITS-1:0] addend;
   logic [COUNT_BITS-1:0] sum;
   logic                  hold;

   always_comb begin
      addend = (op_i == CNT_INC) ? COUNT_BITS'(1) : {COUNT_BITS{1'b1}};
      sum    = cnt_i + addend;
      hold   = ((op_i == CNT_INC) && (&cnt_i)) || ((op_i == CNT_DEC) && (cnt_i == '0));
      cnt_o  = hold ? cnt_i : sum;
      zero_o = (cnt_o == '0);
   end
endmodule

### hdl/refcounted_handle_table_top.sv
// Reference-counted handle table: valid flops, count and payload memories and one
// shared count unit under a one-hot sequencer. Depends on rht_pkg, the interfaces,
// rht_count_unit and the macros header.
// Open scans the slots one per cycle from 0 until it finds a free one; release-all reads
// and writes back every slot in turn. The next beat can be accepted in the same cycle as
// the result is raised. Synchronous reset clears all slots at once.
`include "refcounted_handle_table_top_macros.svh"
module refcounted_handle_table_top #(
   parameter int SLOTS      = rht_pkg::SLOTS_DEF,
   parameter int COUNT_BITS = rht_pkg::COUNT_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   rht_req_if.sink    req_bus,
   rht_rsp_if.source  rsp_bus
);
   import rht_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_SCAN    = 9'b000000010,
      S_CNT_RD  = 9'b000000100,
      S_CNT_WR  = 9'b000001000,
      S_PAY_RD  = 9'b000010000,
      S_WALK_RD = 9'b000100000,
      S_WALK_WR = 9'b001000000,
      S_DONE    = 9'b010000000,
      S_SPARE   = 9'b100000000
   } state_type;

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [HANDLE_W-1:0]   handle_ff, handle_in;
   logic [PAYLOAD_W-1:0]  payload_ff, payload_in;
   status_type            status_ff, status_in;
   logic [HANDLE_W-1:0]   slot_ff, slot_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [SLOTS-1:0]      valid_ff, valid_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [PAYLOAD_W-1:0]  rsp_pout_ff, rsp_pout_in;
   logic                  rsp_open_ff, rsp_open_in;

   logic [COUNT_BITS-1:0] cnt_mem [SLOTS];
   logic [PAYLOAD_W-1:0]  pay_mem [SLOTS];
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [PAYLOAD_W-1:0]  pay_rd_ff;

   logic [IDX_W-1:0]      hidx;
   logic [IDX_W-1:0]      req_idx;
   logic [IDX_W-1:0]      slot_idx;
   logic [IDX_W-1:0]      cnt_rd_addr;
   logic [IDX_W-1:0]      cnt_wr_addr;
   logic [COUNT_BITS-1:0] cnt_wr_data;
   logic                  cnt_wr_en;
   logic                  pay_wr_en;
   logic                  req_live;
   logic                  slot_live;
   logic                  idx_last;
   logic                  req_fire;
   cnt_op_type            unit_op;
   logic [COUNT_BITS-1:0] unit_cnt;
   logic                  unit_zero;

   rht_count_unit #(.COUNT_BITS(COUNT_BITS)) u_count (
      .cnt_i  (cnt_rd_ff),
      .op_i   (unit_op),
      .cnt_o  (unit_cnt),
      .zero_o (unit_zero)
   );

   always_comb begin
      req_fire  = req_bus.valid && req_bus.ready;
      req_idx   = req_bus.handle[IDX_W-1:0];
      req_live  = ({1'b0, req_bus.handle} < (HANDLE_W+1)'(SLOTS)) && valid_ff[req_idx];
      hidx      = handle_ff[IDX_W-1:0];
      slot_idx  = slot_ff[IDX_W-1:0];
      slot_live = ({1'b0, slot_ff} < (HANDLE_W+1)'(SLOTS)) && valid_ff[slot_idx];
      idx_last  = (idx_ff == IDX_W'(SLOTS - 1));
      unit_op   = (cmd_ff == CMD_ADDREF) ? CNT_INC : CNT_DEC;
      cnt_rd_addr = (state_ff == S_WALK_RD) ? idx_ff : hidx;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      handle_in     = handle_ff;
      payload_in    = payload_ff;
      status_in     = status_ff;
      slot_in       = slot_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      cnt_wr_en     = 1'b0;
      cnt_wr_addr   = idx_ff;
      cnt_wr_data   = unit_cnt;
      pay_wr_en     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_pout_in   = rsp_pout_ff;
      rsp_open_in   = rsp_open_ff;
      req_bus.ready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in     = cmd_type'(req_bus.command);
               handle_in  = req_bus.handle;
               payload_in = req_bus.payload;
               slot_in    = req_bus.handle;
               idx_in     = '0;
               status_in  = STAT_OK;
               case (req_bus.command)
                  CMD_OPEN: state_in = S_SCAN;
                  CMD_CLOSE, CMD_ADDREF: begin
                     if (req_live) begin
                        state_in = S_CNT_RD;
                     end else begin
                        status_in = STAT_INVALID;
                        state_in  = S_DONE;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (req_live) begin
                        state_in = S_PAY_RD;
                     end else begin
                        status_in = STAT_INVALID;
                        state_in  = S_DONE;
                     end
                  end
                  CMD_RELEASE_ALL: state_in = S_WALK_RD;
                  default: begin
                     status_in = STAT_INVALID;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (!valid_ff[idx_ff]) begin
               valid_in[idx_ff] = 1'b1;
               cnt_wr_en        = 1'b1;
               cnt_wr_data      = COUNT_BITS'(1);
               pay_wr_en        = 1'b1;
               slot_in          = HANDLE_W'(idx_ff);
               state_in         = S_DONE;
            end else if (idx_last) begin
               status_in = STAT_FULL;
               state_in  = S_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_CNT_RD: state_in = S_CNT_WR;
         S_CNT_WR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = hidx;
            if ((cmd_ff == CMD_CLOSE) && unit_zero) begin
               valid_in[hidx] = 1'b0;
            end
            state_in = S_DONE;
         end
         S_PAY_RD: state_in = S_DONE;
         S_WALK_RD: state_in = S_WALK_WR;
         S_WALK_WR: begin
            if (valid_ff[idx_ff]) begin
               cnt_wr_en = 1'b1;
               if (unit_zero) begin
                  valid_in[idx_ff] = 1'b0;
               end
            end
            if (idx_last) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_WALK_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = slot_ff;
               rsp_pout_in   = ((cmd_ff == CMD_LOOKUP) && (status_ff == STAT_OK)) ?
                               pay_rd_ff : '0;
               rsp_open_in   = (status_ff != STAT_FULL) && slot_live;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      handle_ff     <= handle_in;
      payload_ff    <= payload_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_pout_ff   <= rsp_pout_in;
      rsp_open_ff   <= rsp_open_in;
   end

   always_ff @(posedge clock) begin
      if (cnt_wr_en) begin
         cnt_mem[cnt_wr_addr] <= cnt_wr_data;
      end
      cnt_rd_ff <= cnt_mem[cnt_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pay_wr_en) begin
         pay_mem[idx_ff] <= payload_ff;
      end
      pay_rd_ff <= pay_mem[hidx];
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.slot        = rsp_slot_ff;
   assign rsp_bus.payload_out = rsp_pout_ff;
   assign rsp_bus.is_open     = rsp_open_ff;

   `RHT_ASSERT_SAME(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `RHT_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_fire, state_ff != S_IDLE)
   `RHT_ASSERT_NEXT(a_walk_advance, clock, reset, (state_ff == S_WALK_WR) && !idx_last,
                    (state_ff == S_WALK_RD) && (idx_ff == $past(idx_ff) + IDX_W'(1)))
   `RHT_ASSERT_SAME(a_full_closed, clock, reset,
                    rsp_valid_ff && (rsp_status_ff == STAT_FULL), !rsp_open_ff)
endmodule

### dv/refcounted_handle_table_top_test.sv
// Self-checking test of refcounted_handle_table_top: directed and random beats
// checked against a tracking model of slots, counts and payloads.
// Depends on rht_pkg, rht_req_if, rht_rsp_if and the top level.
module refcounted_handle_table_top_test;
   import rht_pkg::*;

   localparam int SLOTS      = SLOTS_DEF;
   localparam int COUNT_BITS = COUNT_BITS_DEF;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
   localparam logic [CMD_W-1:0]      CMD_SPARE  = CMD_RELEASE_ALL + 1'b1;
   localparam logic [CMD_W-1:0]      CMD_TOP    = '1;
   localparam logic [HANDLE_W-1:0]   HANDLE_TOP = '1;
   localparam logic [PAYLOAD_W-1:0]  WORD_ONES  = '1;
   localparam int IDLE_PCT  = 15;
   localparam int HOLD_LEN  = 300;
   localparam int TAIL_LEN  = 2 * SLOTS + 10;
   localparam int ROUND_LEN = 15;

   typedef struct {
      status_type            status;
      logic [HANDLE_W-1:0]   slot;
      logic [PAYLOAD_W-1:0]  payload_out;
      logic                  is_open;
   } handle_outcome_type;

   class handle_table_scoreboard_type;
      bit                    live[SLOTS];
      logic [COUNT_BITS-1:0] refs[SLOTS];
      logic [PAYLOAD_W-1:0]  words[SLOTS];
      handle_outcome_type    awaited[$];
      int                    mismatches;

      function new();
         foreach (live[i]) begin
            live[i]  = 1'b0;
            refs[i]  = '0;
            words[i] = '0;
         end
         mismatches = 0;
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      function bit is_live(logic [HANDLE_W-1:0] h);
         if (int'(h) >= SLOTS)
            return 1'b0;
         return live[int'(h)];
      endfunction

      function void drop(int i);
         if (refs[i] != '0)
            refs[i] = refs[i] - 1'b1;
         if (refs[i] == '0)
            live[i] = 1'b0;
      endfunction

      function int open_count();
         int n;
         n = 0;
         foreach (live[i])
            if (live[i])
               n++;
         return n;
      endfunction

      function logic [HANDLE_W-1:0] any_open_slot();
         int ids[$];
         foreach (live[i])
            if (live[i])
               ids.push_back(i);
         if (ids.size() == 0)
            return HANDLE_W'($urandom_range(SLOTS - 1));
         return HANDLE_W'(ids[$urandom_range(ids.size() - 1)]);
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_command(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] h,
                                 logic [PAYLOAD_W-1:0] pay);
         handle_outcome_type r;
         bit                 claimed;
         r.status      = STAT_OK;
         r.slot        = h;
         r.payload_out = '0;
         claimed       = 1'b0;
         case (cmd)
            CMD_OPEN: begin
               r.status = STAT_FULL;
               for (int i = 0; i < SLOTS; i++) begin
                  if (!claimed && !live[i]) begin
                     live[i]  = 1'b1;
                     refs[i]  = COUNT_BITS'(1);
                     words[i] = pay;
                     r.slot   = HANDLE_W'(i);
                     r.status = STAT_OK;
                     claimed  = 1'b1;
                  end
               end
            end
            CMD_CLOSE: begin
               if (is_live(h))
                  drop(int'(h));
               else
                  r.status = STAT_INVALID;
            end
            CMD_LOOKUP: begin
               if (is_live(h))
                  r.payload_out = words[int'(h)];
               else
                  r.status = STAT_INVALID;
            end
            CMD_ADDREF: begin
               if (is_live(h)) begin
                  if (refs[int'(h)] != COUNT_MAX)
                     refs[int'(h)] = refs[int'(h)] + 1'b1;
               end else begin
                  r.status = STAT_INVALID;
               end
            end
            CMD_RELEASE_ALL: begin
               foreach (live[i])
                  if (live[i])
                     drop(i);
            end
            default: r.status = STAT_INVALID;
         endcase
         if (cmd == CMD_OPEN && r.status == STAT_FULL)
            r.is_open = 1'b0;
         else
            r.is_open = is_live(r.slot);
         awaited.push_back(r);
      endfunction

      task check_result(logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] sl,
                        logic [PAYLOAD_W-1:0] po, logic op);
         handle_outcome_type e;
         if (awaited.size() == 0) begin
            report("result beat with nothing outstanding");
            return;
         end
         e = awaited.pop_front();
         if (st !== e.status)
            report($sformatf("status %0d, wanted %0d", st, e.status));
         if (sl !== e.slot)
            report($sformatf("slot %0d, wanted %0d", sl, e.slot));
         if (po !== e.payload_out)
            report($sformatf("payload_out %h, wanted %h", po, e.payload_out));
         if (op !== e.is_open)
            report($sformatf("is_open %b, wanted %b", op, e.is_open));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   calm;
   bit   hold_ask;
   int   hold_left;
   handle_table_scoreboard_type sb;

   rht_req_if req_bus();
   rht_rsp_if rsp_bus();

   refcounted_handle_table_top #(
      .SLOTS      (SLOTS),
      .COUNT_BITS (COUNT_BITS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result(rsp_bus.status, rsp_bus.slot, rsp_bus.payload_out, rsp_bus.is_open);
      if (hold_ask) begin
         hold_left = HOLD_LEN;
         hold_ask  = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic send(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] h,
                       logic [PAYLOAD_W-1:0] pay);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.handle  <= h;
      req_bus.payload <= pay;
      do
         @(posedge clock);
      while (!req_bus.ready);
      sb.note_command(cmd, h, pay);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending() != 0);
   endtask

   task automatic fill_table();
      repeat (SLOTS - sb.open_count() + 3)
         send(CMD_OPEN, HANDLE_W'($urandom_range(255)), $urandom());
   endtask

   task automatic random_command();
      int                    r;
      int                    pick;
      logic [CMD_W-1:0]      cmd;
      logic [HANDLE_W-1:0]   h;
      r    = $urandom_range(99);
      pick = $urandom_range(99);
      if (pick < 70)
         h = sb.any_open_slot();
      else if (pick < 90)
         h = HANDLE_W'($urandom_range(SLOTS - 1));
      else
         h = HANDLE_W'($urandom_range(255));
      if (r < 30)
         cmd = CMD_OPEN;
      else if (r < 55)
         cmd = CMD_CLOSE;
      else if (r < 72)
         cmd = CMD_LOOKUP;
      else if (r < 87)
         cmd = CMD_ADDREF;
      else if (r < 90)
         cmd = CMD_RELEASE_ALL;
      else if (r < 93)
         cmd = CMD_W'($urandom_range(CMD_SPARE, CMD_TOP));
      else begin
         cmd = CMD_W'($urandom_range(CMD_TOP));
         h   = HANDLE_W'($urandom_range(255));
      end
      send(cmd, h, $urandom());
   endtask

   initial begin
      logic [HANDLE_W-1:0] h;
      sb              = new();
      reset           = 1'b1;
      calm            = 1'b0;
      hold_ask        = 1'b0;
      hold_left       = 0;
      req_bus.valid   = 1'b0;
      req_bus.command = CMD_OPEN;
      req_bus.handle  = '0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send(CMD_LOOKUP, '0, $urandom());
      send(CMD_CLOSE, '0, $urandom());
      send(CMD_ADDREF, '0, $urandom());
      send(CMD_RELEASE_ALL, HANDLE_TOP, $urandom());
      send(CMD_SPARE, HANDLE_W'(3), $urandom());
      send(CMD_SPARE + 1'b1, '0, $urandom());
      send(CMD_TOP, HANDLE_TOP, $urandom());
      send(CMD_OPEN, 8'hAA, '0);
      send(CMD_OPEN, '0, WORD_ONES);
      send(CMD_LOOKUP, '0, $urandom());
      send(CMD_LOOKUP, HANDLE_W'(1), $urandom());
      send(CMD_ADDREF, '0, $urandom());
      send(CMD_CLOSE, '0, $urandom());
      send(CMD_LOOKUP, '0, $urandom());
      send(CMD_LOOKUP, HANDLE_TOP, $urandom());
      send(CMD_ADDREF, HANDLE_W'(SLOTS), $urandom());
      send(CMD_CLOSE, HANDLE_W'(SLOTS - 1), $urandom());
      send(CMD_TOP, HANDLE_W'(1), $urandom());
      send(CMD_RELEASE_ALL, HANDLE_W'(1), $urandom());
      send(CMD_RELEASE_ALL, '0, $urandom());
      send(CMD_OPEN, HANDLE_TOP, $urandom());
      send(CMD_CLOSE, '0, $urandom());
      send(CMD_LOOKUP, '0, $urandom());

      fill_table();
      h    = sb.any_open_slot();
      calm = 1'b1;
      repeat (int'(COUNT_MAX) + 3)
         send(CMD_ADDREF, h, $urandom());
      calm = 1'b0;
      send(CMD_LOOKUP, h, $urandom());
      send(CMD_CLOSE, h, $urandom());
      send(CMD_RELEASE_ALL, h, $urandom());
      drain();

      for (int round = 0; round < 4; round++) begin
         calm = (round == 0);
         if (round == 2)
            hold_ask = 1'b1;
         if (round % 2 == 1)
            fill_table();
         repeat (ROUND_LEN)
            random_command();
         if (round == 1)
            drain();
      end
      calm = 1'b0;

      drain();
      repeat (TAIL_LEN) @(posedge clock);
      if (sb.pending() != 0)
         sb.report("results still outstanding at the end");
      if (sb.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end
endmodule
